// File: rtl/protobuf_field_encoder_top_defines.svh
// Assertion macros used by the encoder's checker file.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef PROTOBUF_FIELD_ENCODER_TOP_DEFINES_SVH
`define PROTOBUF_FIELD_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PBFE_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pbfe checker: property failed");

// Next-cycle implication, disabled during reset.
`define PBFE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pbfe checker: property failed");

`endif

// File: rtl/pbfe_pkg.sv
// Shared types and constants of the protobuf field encoder.
// No dependencies; used by every design module of the encoder (not by the checker).
package pbfe_pkg;

	localparam int unsigned FnumW = 29;
	localparam int unsigned KeyW = FnumW + 3;
	localparam int unsigned ValW = 64;
	localparam int unsigned QDepth = 2;
	localparam int unsigned QPtrW = $clog2(QDepth);
	localparam int unsigned QCntW = $clog2(QDepth + 1);

	typedef enum logic [2:0] {
		FUNC_VARINT = 3'd0,
		FUNC_ZIGZAG = 3'd1,
		FUNC_FIXED64 = 3'd2,
		FUNC_FIXED32 = 3'd3,
		FUNC_LENGTH = 3'd4,
		FUNC_RAW = 3'd5
	} func_t;

	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_I64 = 3'd1;
	localparam logic [2:0] WT_LEN = 3'd2;
	localparam logic [2:0] WT_I32 = 3'd5;

	typedef enum logic [1:0] {
		MODE_VARINT = 2'd0,
		MODE_LE64 = 2'd1,
		MODE_LE32 = 2'd2,
		MODE_RAW = 2'd3
	} mode_t;

	typedef struct packed {
		logic [KeyW-1:0] key;
		logic has_key;
		mode_t mode;
		logic [ValW-1:0] val;
	} entry_t;

endpackage

// File: rtl/protobuf_field_encoder_top.sv
// An accepted request passes the queue, the serializer's working registers and the
// output byte register. Throughput: one wire byte per cycle while out_stall is low;
// requests are 1 to 15 bytes each, and a request already queued follows with no gap.
// Up to two classified requests wait in the queue while the serializer is busy.
// Reset clears the queue pointers and all valid flags; payload registers keep data.
module protobuf_field_encoder_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] func,
	input logic with_key,
	input logic [28:0] field_num,
	input logic signed [63:0] value,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] out_byte,
	output logic last
);

	logic keep;
	pbfe_pkg::entry_t entry;
	logic q_full;
	logic q_pop;
	logic q_not_empty;
	pbfe_pkg::entry_t q_head;

	pbfe_front u_front (
		.func(func),
		.with_key(with_key),
		.field_num(field_num),
		.value(value),
		.keep(keep),
		.entry(entry)
	);

	pbfe_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(in_valid && keep),
		.push_entry(entry),
		.full(q_full),
		.pop(q_pop),
		.not_empty(q_not_empty),
		.head(q_head)
	);

	pbfe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_not_empty(q_not_empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last(last)
	);

	assign in_stall = q_full;

endmodule

// File: rtl/pbfe_front.sv
// Front part: classifies one field request into a queue entry.
// Depends on pbfe_pkg.
module pbfe_front (
	input logic [2:0] func,
	input logic with_key,
	input logic [pbfe_pkg::FnumW-1:0] field_num,
	input logic signed [pbfe_pkg::ValW-1:0] value,
	output logic keep,
	output pbfe_pkg::entry_t entry
);

	logic [2:0] wt;
	logic [pbfe_pkg::ValW-1:0] zz;

	assign zz = {value[pbfe_pkg::ValW-2:0], 1'b0} ^ {pbfe_pkg::ValW{value[pbfe_pkg::ValW-1]}};

	always_comb begin
		keep = 1'b1;
		wt = pbfe_pkg::WT_VARINT;
		entry.has_key = with_key;
		entry.mode = pbfe_pkg::MODE_VARINT;
		entry.val = value;
		case (func)
			pbfe_pkg::FUNC_VARINT: begin
				wt = pbfe_pkg::WT_VARINT;
			end
			pbfe_pkg::FUNC_ZIGZAG: begin
				wt = pbfe_pkg::WT_VARINT;
				entry.val = zz;
			end
			pbfe_pkg::FUNC_FIXED64: begin
				wt = pbfe_pkg::WT_I64;
				entry.mode = pbfe_pkg::MODE_LE64;
			end
			pbfe_pkg::FUNC_FIXED32: begin
				wt = pbfe_pkg::WT_I32;
				entry.mode = pbfe_pkg::MODE_LE32;
			end
			pbfe_pkg::FUNC_LENGTH: begin
				wt = pbfe_pkg::WT_LEN;
			end
			pbfe_pkg::FUNC_RAW: begin
				entry.has_key = 1'b0;
				entry.mode = pbfe_pkg::MODE_RAW;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
		entry.key = {field_num, wt};
	end

endmodule

// File: rtl/pbfe_queue.sv
// Short queue of classified requests between the front and back parts.
// Depends on pbfe_pkg.
module pbfe_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input pbfe_pkg::entry_t push_entry,
	output logic full,
	input logic pop,
	output logic not_empty,
	output pbfe_pkg::entry_t head
);

	pbfe_pkg::entry_t ent_q [pbfe_pkg::QDepth];
	logic [pbfe_pkg::QPtrW-1:0] wr_ptr_q;
	logic [pbfe_pkg::QPtrW-1:0] rd_ptr_q;
	logic [pbfe_pkg::QCntW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == pbfe_pkg::QCntW'(pbfe_pkg::QDepth));
	assign not_empty = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign head = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + pbfe_pkg::QCntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - pbfe_pkg::QCntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// File: rtl/pbfe_back.sv
// Back part: serializes one queued request into wire bytes, one per cycle while out_stall is low.
// Depends on pbfe_pkg.
module pbfe_back (
	input logic clk,
	input logic arst_n,
	input logic q_not_empty,
	input pbfe_pkg::entry_t q_head,
	output logic q_pop,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] out_byte,
	output logic last
);

	logic wk_valid_q;
	logic phase_key_q;
	logic [pbfe_pkg::KeyW-1:0] key_q;
	pbfe_pkg::mode_t mode_q;
	logic [pbfe_pkg::ValW-1:0] val_q;
	logic [2:0] cnt_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic last_q;

	logic advance;
	logic load;
	logic key_more;
	logic val_more;
	logic [7:0] nb;
	logic nl;

	assign advance = !out_valid_q || !out_stall;
	assign key_more = |key_q[pbfe_pkg::KeyW-1:7];
	assign val_more = |val_q[pbfe_pkg::ValW-1:7];

	always_comb begin
		nb = val_q[7:0];
		nl = 1'b1;
		if (phase_key_q) begin
			nb = {key_more, key_q[6:0]};
			nl = 1'b0;
		end else begin
			case (mode_q)
				pbfe_pkg::MODE_VARINT: begin
					nb = {val_more, val_q[6:0]};
					nl = !val_more;
				end
				pbfe_pkg::MODE_LE64, pbfe_pkg::MODE_LE32: begin
					nl = (cnt_q == 3'd0);
				end
				default: begin
					nl = 1'b1;
				end
			endcase
		end
	end

	assign load = advance && (!wk_valid_q || nl);
	assign q_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wk_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= wk_valid_q;
			if (load) begin
				wk_valid_q <= q_not_empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= nb;
			last_q <= nl;
			if (load) begin
				key_q <= q_head.key;
				phase_key_q <= q_head.has_key;
				mode_q <= q_head.mode;
				val_q <= q_head.val;
				cnt_q <= (q_head.mode == pbfe_pkg::MODE_LE64) ? 3'd7 : 3'd3;
			end else if (phase_key_q) begin
				key_q <= {7'd0, key_q[pbfe_pkg::KeyW-1:7]};
				phase_key_q <= key_more;
			end else if (mode_q == pbfe_pkg::MODE_VARINT) begin
				val_q <= {7'd0, val_q[pbfe_pkg::ValW-1:7]};
			end else begin
				val_q <= {8'd0, val_q[pbfe_pkg::ValW-1:8]};
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign last = last_q;

endmodule

// File: rtl/pbfe_checker.sv
// Port-level checker for the protobuf field encoder, bound to the top level.
// Depends on protobuf_field_encoder_top_defines.svh.
`include "protobuf_field_encoder_top_defines.svh"

module pbfe_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [7:0] out_byte,
	input logic last
);

	`PBFE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(last))
	`PBFE_ASSERT_NEXT(a_burst_gapless, out_valid && !out_stall && !last, out_valid)
	`PBFE_ASSERT_IMPLY(a_stall_cause, in_stall, $past(in_valid) || $past(in_stall))

endmodule

bind protobuf_field_encoder_top pbfe_checker u_pbfe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_byte(out_byte),
	.last(last)
);
